[rtl/i2cwr_pkg.sv]
// Shared types and constants for the I2C write/read sequencer.
// Holds buffer sizing, phase encoding and bus command codes; no dependencies.
`timescale 1ns / 1ps

package i2cwr_pkg;

   localparam int WRITE_DEPTH = 16;
   localparam int ADDR_W      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(WRITE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_TRANSMIT = 3'd2,
      CMD_RESTART  = 3'd3,
      CMD_RECEIVE  = 3'd4,
      CMD_ACK      = 3'd5,
      CMD_NACK     = 3'd6,
      CMD_STOP     = 3'd7
   } cmd_type;

   typedef enum logic [9:0] {
      PH_IDLE      = 10'b00_0000_0001,
      PH_START     = 10'b00_0000_0010,
      PH_WRITE     = 10'b00_0000_0100,
      PH_RESTART   = 10'b00_0000_1000,
      PH_ADDR_READ = 10'b00_0001_0000,
      PH_READ      = 10'b00_0010_0000,
      PH_ACK       = 10'b00_0100_0000,
      PH_NACK      = 10'b00_1000_0000,
      PH_STOP      = 10'b01_0000_0000,
      PH_ERROR     = 10'b10_0000_0000
   } phase_type;

endpackage

[rtl/i2cwr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module i2cwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/i2c_master_write_read_sequencer.sv]
// Top level of the I2C combined write/read transaction sequencer.
// Depends on i2cwr_pkg and i2cwr_ram (write byte buffer).
//
//  channel | dir | handshake           | contents
//  req     | in  | req_tvalid/tready   | tuser: operation; tdata: load, start and event fields
//  rsp     | out | rsp_tvalid/tready   | tuser: bus_command; tdata: byte and status fields
//
// One beat in, one beat out; a beat is taken every cycle while the output
// register is empty or being drained, result in the cycle after acceptance.
// The buffer RAM is read every cycle at the next write position; a load to
// that entry in the same cycle is forwarded. Reset clears the phase, counters
// and the output valid flag; result data and buffer contents are not cleared.
`timescale 1ns / 1ps

module i2c_master_write_read_sequencer
   import i2cwr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] operation
   input  logic [1:0]  req_tuser,
   // [7:0] write_byte, [14:8] target_address, [19:15] write_length,
   // [27:20] read_length, [28] ack_missing, [36:29] received_byte,
   // [37] bus_collision, [39:38] zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] bus_command
   output logic [2:0]  rsp_tuser,
   // [7:0] transmit_byte, [15:8] read_data, [16] read_valid,
   // [24:17] read_position, [25] done_res, [26] failed, [31:27] zero
   output logic [31:0] rsp_tdata
);

   phase_type        phase_ff, phase_in;
   logic [6:0]       addr_ff, addr_in;
   logic [CNT_W-1:0] btw_ff, btw_in;
   logic [7:0]       btr_ff, btr_in;
   logic [CNT_W-1:0] wpos_ff, wpos_in;
   logic [7:0]       rcnt_ff, rcnt_in;
   logic [CNT_W-1:0] lpos_ff, lpos_in;

   logic             fwd_hit_ff;
   logic [7:0]       fwd_data_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_user_ff;
   logic [31:0]      rsp_data_ff;

   logic             accept;
   op_type           op;
   logic [7:0]       write_byte;
   logic [6:0]       target_address;
   logic [4:0]       write_length;
   logic [7:0]       read_length;
   logic             ack_missing;
   logic [7:0]       received_byte;
   logic             bus_collision;

   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_rdata, buf_byte;
   logic [7:0]       rcnt_inc;

   cmd_type          cmd;
   logic [7:0]       tx, rdata, rpos;
   logic             rvalid, done;

   assign req_tready     = !rsp_valid_ff || rsp_tready;
   assign accept         = req_tvalid && req_tready;
   assign op             = op_type'(req_tuser);
   assign write_byte     = req_tdata[7:0];
   assign target_address = req_tdata[14:8];
   assign write_length   = req_tdata[19:15];
   assign read_length    = req_tdata[27:20];
   assign ack_missing    = req_tdata[28];
   assign received_byte  = req_tdata[36:29];
   assign bus_collision  = req_tdata[37];

   assign buf_byte = fwd_hit_ff ? fwd_data_ff : mem_rdata;
   assign rcnt_inc = rcnt_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      btw_in   = btw_ff;
      btr_in   = btr_ff;
      wpos_in  = wpos_ff;
      rcnt_in  = rcnt_ff;
      lpos_in  = lpos_ff;
      mem_we   = 1'b0;
      cmd      = CMD_NONE;
      tx       = 8'd0;
      rdata    = 8'd0;
      rvalid   = 1'b0;
      rpos     = 8'd0;
      done     = 1'b0;
      if (accept) begin
         unique case (op)
            OP_LOAD: begin
               if (32'(lpos_ff) < WRITE_DEPTH) begin
                  mem_we  = 1'b1;
                  lpos_in = lpos_ff + CNT_W'(1);
               end
            end
            OP_START: begin
               addr_in  = target_address;
               btw_in   = (32'(write_length) > WRITE_DEPTH) ? CNT_W'(WRITE_DEPTH)
                                                            : CNT_W'(write_length);
               btr_in   = read_length;
               wpos_in  = '0;
               rcnt_in  = 8'd0;
               lpos_in  = '0;
               phase_in = PH_START;
               cmd      = CMD_START;
            end
            OP_EVENT: begin
               if (bus_collision || phase_ff == PH_IDLE || phase_ff == PH_ERROR) begin
                  phase_in = PH_ERROR;
               end else begin
                  unique case (phase_ff)
                     PH_START: begin
                        wpos_in = '0;
                        rcnt_in = 8'd0;
                        cmd     = CMD_TRANSMIT;
                        if (btw_ff != '0 || btr_ff == 8'd0) begin
                           tx       = {addr_ff, 1'b0};
                           phase_in = PH_WRITE;
                        end else begin
                           tx       = {addr_ff, 1'b1};
                           phase_in = PH_ADDR_READ;
                        end
                     end
                     PH_WRITE: begin
                        priority if (ack_missing) begin
                           phase_in = PH_ERROR;
                        end else if (wpos_ff < btw_ff) begin
                           cmd     = CMD_TRANSMIT;
                           tx      = buf_byte;
                           wpos_in = wpos_ff + CNT_W'(1);
                        end else if (btr_ff != 8'd0) begin
                           cmd      = CMD_RESTART;
                           phase_in = PH_RESTART;
                        end else begin
                           cmd      = CMD_STOP;
                           phase_in = PH_STOP;
                        end
                     end
                     PH_RESTART: begin
                        cmd      = CMD_TRANSMIT;
                        tx       = {addr_ff, 1'b1};
                        phase_in = PH_ADDR_READ;
                     end
                     PH_ADDR_READ: begin
                        if (ack_missing) begin
                           phase_in = PH_ERROR;
                        end else begin
                           cmd      = CMD_RECEIVE;
                           phase_in = PH_READ;
                        end
                     end
                     PH_READ: begin
                        rdata   = received_byte;
                        rvalid  = 1'b1;
                        rpos    = rcnt_ff;
                        rcnt_in = rcnt_inc;
                        if (rcnt_inc >= btr_ff) begin
                           cmd      = CMD_NACK;
                           phase_in = PH_NACK;
                        end else begin
                           cmd      = CMD_ACK;
                           phase_in = PH_ACK;
                        end
                     end
                     PH_ACK: begin
                        cmd      = CMD_RECEIVE;
                        phase_in = PH_READ;
                     end
                     PH_NACK: begin
                        cmd      = CMD_STOP;
                        phase_in = PH_STOP;
                     end
                     PH_STOP: begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                     default: begin
                        phase_in = PH_ERROR;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign mem_waddr = lpos_ff[ADDR_W-1:0];
   assign mem_raddr = wpos_in[ADDR_W-1:0];

   i2cwr_ram #(
      .WIDTH (8),
      .DEPTH (WRITE_DEPTH)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (write_byte),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      fwd_hit_ff  <= mem_we && (mem_waddr == mem_raddr);
      fwd_data_ff <= write_byte;
      if (accept) begin
         rsp_user_ff <= cmd;
         rsp_data_ff <= {5'd0, phase_in == PH_ERROR, done, rpos, rvalid, rdata, tx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         addr_ff      <= 7'd0;
         btw_ff       <= '0;
         btr_ff       <= 8'd0;
         wpos_ff      <= '0;
         rcnt_ff      <= 8'd0;
         lpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         btw_ff   <= btw_in;
         btr_ff   <= btr_in;
         wpos_ff  <= wpos_in;
         rcnt_ff  <= rcnt_in;
         lpos_ff  <= lpos_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/i2cwr_checker.sv]
// Port-level checks for the I2C write/read sequencer, bound to its top level.
// Depends on i2cwr_pkg for the bus command codes.
`timescale 1ns / 1ps

module i2cwr_checker
   import i2cwr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [31:0] rsp_tdata
);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_read_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |->
         rsp_tuser == CMD_ACK || rsp_tuser == CMD_NACK)
      else $error("received byte without ack or nack");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |->
         rsp_tuser == CMD_NONE && !rsp_tdata[26] && !rsp_tdata[16])
      else $error("done beat carries command or failure");

endmodule

bind i2c_master_write_read_sequencer i2cwr_checker u_i2cwr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

[test/tb.sv]
// Self-checking bench for the I2C write/read sequencer: bursts of load, start and bus-event
// beats against a built-in phase predictor, with random stalls on the result side.
// Depends on i2cwr_pkg and i2c_master_write_read_sequencer.
`timescale 1ns / 1ps

module tb
   import i2cwr_pkg::*;
();

   typedef struct packed {
      logic [1:0] pad;
      logic       collision;
      logic [7:0] received_byte;
      logic       ack_missing;
      logic [7:0] read_length;
      logic [4:0] write_length;
      logic [6:0] target_address;
      logic [7:0] write_byte;
   } req_fields_type;

   typedef struct packed {
      logic [1:0]     op;
      req_fields_type f;
   } req_item_type;

   typedef struct packed {
      logic [4:0] pad;
      logic       failed;
      logic       done;
      logic [7:0] read_position;
      logic       read_valid;
      logic [7:0] read_data;
      logic [7:0] transmit_byte;
   } rsp_fields_type;

   typedef struct packed {
      cmd_type        cmd;
      rsp_fields_type f;
   } bus_result_type;

   typedef enum {FLAW_NONE, FLAW_NACK, FLAW_COLLISION, FLAW_CUT, FLAW_EXTRA} flaw_kind_type;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [31:0] rsp_tdata;

   i2c_master_write_read_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_item_type   bus_item_q[$];
   bus_result_type awaited_rsp_q[$];
   int             mismatches = 0;
   int             rsp_index = 0;

   // predicted sequencer state
   phase_type   phase_now = PH_IDLE;
   logic [6:0]  slave_addr = '0;
   int          bytes_wr = 0;
   logic [7:0]  bytes_rd = '0;
   int          wr_pos = 0;
   logic [7:0]  rd_count = '0;
   int          load_pos = 0;
   logic [7:0]  wbuf [WRITE_DEPTH];

   function automatic bus_result_type sequence_bus_item(req_item_type it);
      bus_result_type r;
      r = '0;
      r.cmd = CMD_NONE;
      if (it.op == OP_LOAD) begin
         if (load_pos < WRITE_DEPTH) begin
            wbuf[load_pos] = it.f.write_byte;
            load_pos++;
         end
      end else if (it.op == OP_START) begin
         slave_addr = it.f.target_address;
         bytes_wr = (it.f.write_length > WRITE_DEPTH) ? WRITE_DEPTH : int'(it.f.write_length);
         bytes_rd = it.f.read_length;
         wr_pos = 0;
         rd_count = '0;
         load_pos = 0;
         phase_now = PH_START;
         r.cmd = CMD_START;
      end else if (it.op == OP_EVENT) begin
         if (it.f.collision || phase_now == PH_IDLE || phase_now == PH_ERROR) begin
            phase_now = PH_ERROR;
         end else begin
            case (phase_now)
               PH_START: begin
                  wr_pos = 0;
                  rd_count = '0;
                  r.cmd = CMD_TRANSMIT;
                  if (bytes_wr > 0 || bytes_rd == 0) begin
                     r.f.transmit_byte = {slave_addr, 1'b0};
                     phase_now = PH_WRITE;
                  end else begin
                     r.f.transmit_byte = {slave_addr, 1'b1};
                     phase_now = PH_ADDR_READ;
                  end
               end
               PH_WRITE: begin
                  if (it.f.ack_missing) begin
                     phase_now = PH_ERROR;
                  end else if (wr_pos < bytes_wr) begin
                     r.cmd = CMD_TRANSMIT;
                     r.f.transmit_byte = wbuf[wr_pos];
                     wr_pos++;
                  end else if (bytes_rd != 0) begin
                     r.cmd = CMD_RESTART;
                     phase_now = PH_RESTART;
                  end else begin
                     r.cmd = CMD_STOP;
                     phase_now = PH_STOP;
                  end
               end
               PH_RESTART: begin
                  r.cmd = CMD_TRANSMIT;
                  r.f.transmit_byte = {slave_addr, 1'b1};
                  phase_now = PH_ADDR_READ;
               end
               PH_ADDR_READ: begin
                  if (it.f.ack_missing) begin
                     phase_now = PH_ERROR;
                  end else begin
                     r.cmd = CMD_RECEIVE;
                     phase_now = PH_READ;
                  end
               end
               PH_READ: begin
                  r.f.read_data = it.f.received_byte;
                  r.f.read_valid = 1'b1;
                  r.f.read_position = rd_count;
                  rd_count = rd_count + 8'd1;
                  if (rd_count >= bytes_rd) begin
                     r.cmd = CMD_NACK;
                     phase_now = PH_NACK;
                  end else begin
                     r.cmd = CMD_ACK;
                     phase_now = PH_ACK;
                  end
               end
               PH_ACK: begin
                  r.cmd = CMD_RECEIVE;
                  phase_now = PH_READ;
               end
               PH_NACK: begin
                  r.cmd = CMD_STOP;
                  phase_now = PH_STOP;
               end
               PH_STOP: begin
                  r.f.done = 1'b1;
                  phase_now = PH_IDLE;
               end
               default: begin
                  phase_now = PH_ERROR;
               end
            endcase
         end
      end
      r.f.failed = (phase_now == PH_ERROR);
      return r;
   endfunction

   function automatic req_item_type make_item(logic [1:0] op);
      req_item_type it;
      it.op = op;
      it.f.pad = '0;
      it.f.write_byte = 8'($urandom_range(0, 255));
      it.f.target_address = 7'($urandom_range(0, 127));
      it.f.write_length = 5'($urandom_range(0, 31));
      it.f.read_length = 8'($urandom_range(0, 255));
      it.f.received_byte = 8'($urandom_range(0, 255));
      it.f.ack_missing = (op == OP_EVENT) ? 1'b0 : 1'($urandom_range(0, 1));
      it.f.collision = (op == OP_EVENT) ? 1'b0 : 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic add_transaction(input logic [6:0] addr, input logic [4:0] wl,
                                  input logic [7:0] rl, input flaw_kind_type flaw);
      req_item_type it;
      int wr;
      int n;
      int bad;
      wr = (wl > WRITE_DEPTH) ? WRITE_DEPTH : int'(wl);
      n = 2;
      if (wr > 0 || rl == 0) n += wr + 1;
      if (rl != 0) n += ((wr > 0) ? 1 : 0) + 1 + 2 * int'(rl);
      it = make_item(OP_START);
      it.f.target_address = addr;
      it.f.write_length = wl;
      it.f.read_length = rl;
      bus_item_q.push_back(it);
      bad = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
         if (flaw == FLAW_CUT && i == bad) break;
         it = make_item(OP_EVENT);
         // ack status is ignored from the first received byte through the stop
         if (i >= n - 2 * int'(rl) - 1) it.f.ack_missing = 1'($urandom_range(0, 1));
         if (flaw == FLAW_NACK && i == bad) it.f.ack_missing = 1'b1;
         if (flaw == FLAW_COLLISION && i == bad) it.f.collision = 1'b1;
         bus_item_q.push_back(it);
         if ($urandom_range(0, 19) == 0) bus_item_q.push_back(make_item(OP_LOAD));
      end
      if (flaw == FLAW_EXTRA) begin
         repeat ($urandom_range(1, 3)) bus_item_q.push_back(make_item(OP_EVENT));
      end
   endtask

   // sender: bursts with random gaps, valid held until taken
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_rsp_q.push_back(sequence_bus_item(req_item_type'({req_tuser, req_tdata})));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (bus_item_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser <= bus_item_q[0].op;
               req_tdata <= bus_item_q[0].f;
               void'(bus_item_q.pop_front());
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // long hold-off on the result side once traffic is flowing
   int hold_cycles = 0;
   int beats_seen = 0;
   bit hold_started = 1'b0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) beats_seen <= beats_seen + 1;
         if (!hold_started && beats_seen >= 600) begin
            hold_started <= 1'b1;
            hold_cycles <= 400;
         end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
         end
      end
   end

   // receiver: runs of always-ready, choppy and mostly-stalled
   int stall_mode = 0;
   int stall_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run = $urandom_range(5, 60);
         end else begin
            stall_run--;
         end
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_mode == 0) begin
            rsp_tready <= 1'b1;
         end else if (stall_mode == 1) begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end else begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("response %0d: %s is %0d, expected %0d", rsp_index, field, got, want);
      mismatches++;
   endtask

   bus_result_type want_rsp;
   rsp_fields_type got_f;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_f = rsp_tdata;
         if (awaited_rsp_q.size() == 0) begin
            flag_mismatch("unexpected beat, command", int'(rsp_tuser), 0);
         end else begin
            want_rsp = awaited_rsp_q.pop_front();
            if (rsp_tuser != want_rsp.cmd)
               flag_mismatch("bus_command", int'(rsp_tuser), int'(want_rsp.cmd));
            if (got_f.transmit_byte != want_rsp.f.transmit_byte)
               flag_mismatch("transmit_byte", got_f.transmit_byte, want_rsp.f.transmit_byte);
            if (got_f.read_data != want_rsp.f.read_data)
               flag_mismatch("read_data", got_f.read_data, want_rsp.f.read_data);
            if (got_f.read_valid != want_rsp.f.read_valid)
               flag_mismatch("read_valid", got_f.read_valid, want_rsp.f.read_valid);
            if (got_f.read_position != want_rsp.f.read_position)
               flag_mismatch("read_position", got_f.read_position, want_rsp.f.read_position);
            if (got_f.done != want_rsp.f.done)
               flag_mismatch("done_res", got_f.done, want_rsp.f.done);
            if (got_f.failed != want_rsp.f.failed)
               flag_mismatch("failed", got_f.failed, want_rsp.f.failed);
         end
         rsp_index++;
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_item_type  it;
      logic [4:0]    wl;
      logic [7:0]    rl;
      flaw_kind_type flaw;

      // fill every buffer entry, extremes first, then one load past full
      for (int i = 0; i < WRITE_DEPTH + 1; i++) begin
         it = make_item(OP_LOAD);
         if (i == 0) it.f.write_byte = 8'h00;
         if (i == 1) it.f.write_byte = 8'hFF;
         bus_item_q.push_back(it);
      end
      bus_item_q.push_back(make_item(OP_EVENT));
      bus_item_q.push_back(make_item(OP_UNKNOWN));
      add_transaction(7'h00, 5'd0, 8'd0, FLAW_NONE);
      add_transaction(7'h7F, 5'd31, 8'd255, FLAW_NONE);

      while (bus_item_q.size() < 2100) begin
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4))
            bus_item_q.push_back(make_item(OP_LOAD));
         if ($urandom_range(0, 29) == 0) bus_item_q.push_back(make_item(OP_UNKNOWN));
         wl = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
         rl = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 4));
         flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : flaw_kind_type'($urandom_range(1, 4));
         add_transaction(7'($urandom_range(0, 127)), wl, rl, flaw);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (bus_item_q.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/i2cwr_pkg.sv
rtl/i2cwr_ram.sv
rtl/i2c_master_write_read_sequencer.sv
rtl/i2cwr_checker.sv
test/tb.sv
